/* src/arpc_pkg.sv */
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the ARP resolution cache.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int CACHE_ENTRIES_DEF = 16;
    localparam int PENDING_IPS_DEF   = 8;
    localparam int PENDING_SLOTS_DEF = 16;

    localparam logic [15:0] HOLDOFF_RESET  = 16'd5000;
    localparam logic [15:0] LIFETIME_RESET = 16'd30000;
    localparam logic [47:0] BCAST_MAC      = 48'hFFFF_FFFF_FFFF;

    // Operation codes
    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_RECV = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // Frame kinds
    localparam logic [1:0] FK_IPV4 = 2'd0;
    localparam logic [1:0] FK_ARP  = 2'd1;

    // Result kinds
    localparam logic [2:0] RK_FRAME   = 3'd0;
    localparam logic [2:0] RK_REQUEST = 3'd1;
    localparam logic [2:0] RK_REPLY   = 3'd2;
    localparam logic [2:0] RK_DELIVER = 3'd3;
    localparam logic [2:0] RK_DROP    = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_OWN_MAC  = 2'd0;
    localparam logic [1:0] CFG_OWN_IP   = 2'd1;
    localparam logic [1:0] CFG_HOLDOFF  = 2'd2;
    localparam logic [1:0] CFG_LIFETIME = 2'd3;

    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [47:0] mac;
        logic [31:0] ip;
        logic [15:0] handle;
    } result_t;

endpackage

/* src/arpc_out.sv */
// ----------------------------------------------------------------------------
// arpc_out
// Result stage: holds the newest result back by one so that the final result
// of a transaction can be marked with last.
// ----------------------------------------------------------------------------
module arpc_out
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  arpc_pkg::result_t     emit,
    input  logic                  finish,
    output logic                  strobe,
    output logic [2:0]            result_kind,
    output logic [47:0]           out_dst_mac,
    output logic [31:0]           out_target_ip,
    output logic [15:0]           out_handle,
    output logic                  last
);

    arpc_pkg::result_t hold_reg;
    logic              strobe_reg;
    logic              last_reg;
    logic [2:0]        kind_reg;
    logic [47:0]       mac_reg;
    logic [31:0]       ip_reg;
    logic [15:0]       handle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg.valid <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            if (emit.valid)
            begin
                hold_reg <= emit;
                if (hold_reg.valid)
                begin
                    strobe_reg <= 1'b1;
                    last_reg   <= 1'b0;
                    kind_reg   <= hold_reg.kind;
                    mac_reg    <= hold_reg.mac;
                    ip_reg     <= hold_reg.ip;
                    handle_reg <= hold_reg.handle;
                end
            end
            else if (finish && hold_reg.valid)
            begin
                hold_reg.valid <= 1'b0;
                strobe_reg     <= 1'b1;
                last_reg       <= 1'b1;
                kind_reg       <= hold_reg.kind;
                mac_reg        <= hold_reg.mac;
                ip_reg         <= hold_reg.ip;
                handle_reg     <= hold_reg.handle;
            end
        end
    end

    assign strobe        = strobe_reg;
    assign last          = last_reg;
    assign result_kind   = kind_reg;
    assign out_dst_mac   = mac_reg;
    assign out_target_ip = ip_reg;
    assign out_handle    = handle_reg;

endmodule

/* src/arp_resolution_cache_unit.sv */
// ----------------------------------------------------------------------------
// arp_resolution_cache_unit
// ARP cache with a queue of datagrams waiting for address resolution.
//
//   channel   handshake            payload
//   input     start / busy         operation, peer_ip, peer_mac, arp_target_ip,
//                                  frame_dst_mac, frame_kind, arp_is_request,
//                                  payload_ok, datagram_handle, elapsed_ms
//   result    strobe (one cycle)   result_kind, out_dst_mac, out_target_ip,
//                                  out_handle, last
//   config    cfg_write            cfg_index, cfg_data
//
// One sequencer walks the tables one entry per cycle with a single compare
// unit. A send scans the cache and, on a miss, the pending IPs and slots;
// a tick walks the largest table; an ARP frame scans the cache and pending
// IPs, then makes one slot pass per released datagram and one more. busy is high
// throughout. Reset clears all valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module arp_resolution_cache_unit
#(
    parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF,
    parameter int PENDING_IPS   = arpc_pkg::PENDING_IPS_DEF,
    parameter int PENDING_SLOTS = arpc_pkg::PENDING_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [31:0] peer_ip,
    input  logic [47:0] peer_mac,
    input  logic [31:0] arp_target_ip,
    input  logic [47:0] frame_dst_mac,
    input  logic [1:0]  frame_kind,
    input  logic        arp_is_request,
    input  logic        payload_ok,
    input  logic [15:0] datagram_handle,
    input  logic [15:0] elapsed_ms,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    output logic        strobe,
    output logic [2:0]  result_kind,
    output logic [47:0] out_dst_mac,
    output logic [31:0] out_target_ip,
    output logic [15:0] out_handle,
    output logic        last
);

    localparam int MAXN = (CACHE_ENTRIES > PENDING_IPS)
                        ? ((CACHE_ENTRIES > PENDING_SLOTS) ? CACHE_ENTRIES : PENDING_SLOTS)
                        : ((PENDING_IPS > PENDING_SLOTS) ? PENDING_IPS : PENDING_SLOTS);
    localparam int IW = (MAXN > 1) ? $clog2(MAXN) : 1;
    localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int PW = (PENDING_IPS > 1) ? $clog2(PENDING_IPS) : 1;
    localparam int SW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
    localparam logic [IW-1:0] C_LAST = IW'(CACHE_ENTRIES - 1);
    localparam logic [IW-1:0] P_LAST = IW'(PENDING_IPS - 1);
    localparam logic [IW-1:0] S_LAST = IW'(PENDING_SLOTS - 1);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b000000000001,
        ST_CSCAN  = 12'b000000000010,
        ST_PSCAN  = 12'b000000000100,
        ST_SSCAN  = 12'b000000001000,
        ST_QUEUE  = 12'b000000010000,
        ST_LSCAN  = 12'b000000100000,
        ST_LWRITE = 12'b000001000000,
        ST_RPSCAN = 12'b000010000000,
        ST_RSLOT  = 12'b000100000000,
        ST_REPLY  = 12'b001000000000,
        ST_TICK   = 12'b010000000000,
        ST_FINISH = 12'b100000000000
    } state_t;

    state_t state_reg;

    // Configuration
    logic [47:0] own_mac_reg;
    logic [31:0] own_ip_reg;
    logic [15:0] holdoff_reg;
    logic [15:0] lifetime_reg;

    // Tables
    logic [CACHE_ENTRIES-1:0] cache_valid_reg;
    logic [31:0]              cache_ip_reg  [CACHE_ENTRIES];
    logic [47:0]              cache_mac_reg [CACHE_ENTRIES];
    logic [15:0]              cache_age_reg [CACHE_ENTRIES];
    logic [PENDING_IPS-1:0]   pend_valid_reg;
    logic [31:0]              pend_ip_reg    [PENDING_IPS];
    logic [15:0]              pend_timer_reg [PENDING_IPS];
    logic [PENDING_SLOTS-1:0] slot_valid_reg;
    logic [PW-1:0]            slot_owner_reg  [PENDING_SLOTS];
    logic [15:0]              slot_handle_reg [PENDING_SLOTS];
    logic [SW-1:0]            slot_seq_reg    [PENDING_SLOTS];

    // Latched transaction
    logic [31:0] ip_reg;
    logic [47:0] mac_reg;
    logic [31:0] tgt_reg;
    logic        req_reg;
    logic [15:0] handle_reg;
    logic [15:0] elapsed_reg;

    // Scan bookkeeping
    logic [IW-1:0] idx_reg;
    logic          hit_reg;
    logic [CW-1:0] hit_idx_reg;
    logic          cfree_reg;
    logic [CW-1:0] cfree_idx_reg;
    logic [CW-1:0] old_idx_reg;
    logic [15:0]   old_age_reg;
    logic          pfound_reg;
    logic [PW-1:0] p_idx_reg;
    logic          pfree_reg;
    logic [PW-1:0] pfree_idx_reg;
    logic          sfree_reg;
    logic [SW-1:0] s_idx_reg;
    logic [SW-1:0] cnt_reg;
    logic [SW:0]   q_reg;
    logic          any_reg;

    arpc_pkg::result_t emit;
    logic              finish;

    logic [CW-1:0] ci;
    logic [PW-1:0] pi;
    logic [SW-1:0] si;
    logic [PW-1:0] p_sel;
    logic [16:0]   age_sum;
    logic [16:0]   timer_sum;
    logic [15:0]   age_sat;
    logic [15:0]   timer_sat;
    logic          addressed;

    assign ci        = idx_reg[CW-1:0];
    assign pi        = idx_reg[PW-1:0];
    assign si        = idx_reg[SW-1:0];
    assign p_sel     = pfound_reg ? p_idx_reg : pfree_idx_reg;
    assign age_sum   = {1'b0, cache_age_reg[ci]} + {1'b0, elapsed_reg};
    assign timer_sum = {1'b0, pend_timer_reg[pi]} + {1'b0, elapsed_reg};
    assign age_sat   = age_sum[16] ? 16'hFFFF : age_sum[15:0];
    assign timer_sat = timer_sum[16] ? 16'hFFFF : timer_sum[15:0];
    assign addressed = (frame_dst_mac == own_mac_reg) || (frame_dst_mac == arpc_pkg::BCAST_MAC);

    assign busy   = (state_reg != ST_IDLE);
    assign finish = (state_reg == ST_FINISH);

    // Result produced this cycle, if any.
    always_comb
    begin
        emit = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && operation == arpc_pkg::OP_RECV && addressed && payload_ok
                    && frame_kind == arpc_pkg::FK_IPV4)
                begin
                    emit.valid  = 1'b1;
                    emit.kind   = arpc_pkg::RK_DELIVER;
                    emit.handle = datagram_handle;
                end
            end
            ST_CSCAN:
            begin
                if (cache_valid_reg[ci] && cache_ip_reg[ci] == ip_reg)
                begin
                    emit.valid  = 1'b1;
                    emit.kind   = arpc_pkg::RK_FRAME;
                    emit.mac    = cache_mac_reg[ci];
                    emit.handle = handle_reg;
                end
            end
            ST_QUEUE:
            begin
                if (!(pfound_reg || pfree_reg) || !sfree_reg)
                begin
                    emit.valid  = 1'b1;
                    emit.kind   = arpc_pkg::RK_DROP;
                    emit.handle = handle_reg;
                end
                else if (!pfound_reg || pend_timer_reg[p_idx_reg] >= holdoff_reg)
                begin
                    emit.valid = 1'b1;
                    emit.kind  = arpc_pkg::RK_REQUEST;
                    emit.mac   = arpc_pkg::BCAST_MAC;
                    emit.ip    = ip_reg;
                end
            end
            ST_RSLOT:
            begin
                if (slot_valid_reg[si] && slot_owner_reg[si] == p_idx_reg
                    && {1'b0, slot_seq_reg[si]} == q_reg)
                begin
                    emit.valid  = 1'b1;
                    emit.kind   = arpc_pkg::RK_FRAME;
                    emit.mac    = mac_reg;
                    emit.handle = slot_handle_reg[si];
                end
            end
            ST_REPLY:
            begin
                if (req_reg && tgt_reg == own_ip_reg)
                begin
                    emit.valid = 1'b1;
                    emit.kind  = arpc_pkg::RK_REPLY;
                    emit.mac   = mac_reg;
                    emit.ip    = ip_reg;
                end
            end
            default:
            begin
                emit = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg  <= '0;
            own_ip_reg   <= '0;
            holdoff_reg  <= arpc_pkg::HOLDOFF_RESET;
            lifetime_reg <= arpc_pkg::LIFETIME_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                arpc_pkg::CFG_OWN_MAC:  own_mac_reg  <= cfg_data;
                arpc_pkg::CFG_OWN_IP:   own_ip_reg   <= cfg_data[31:0];
                arpc_pkg::CFG_HOLDOFF:  holdoff_reg  <= cfg_data[15:0];
                arpc_pkg::CFG_LIFETIME: lifetime_reg <= cfg_data[15:0];
                default:                own_ip_reg   <= own_ip_reg;
            endcase
        end
    end

    // Payload tables and latched fields carry no reset.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            ip_reg      <= peer_ip;
            mac_reg     <= peer_mac;
            tgt_reg     <= arp_target_ip;
            req_reg     <= arp_is_request;
            handle_reg  <= datagram_handle;
            elapsed_reg <= elapsed_ms;
        end
        case (state_reg)
            ST_QUEUE:
            begin
                if ((pfound_reg || pfree_reg) && sfree_reg)
                begin
                    slot_owner_reg[s_idx_reg]  <= p_sel;
                    slot_handle_reg[s_idx_reg] <= handle_reg;
                    slot_seq_reg[s_idx_reg]    <= cnt_reg;
                    if (!pfound_reg)
                    begin
                        pend_ip_reg[pfree_idx_reg]    <= ip_reg;
                        pend_timer_reg[pfree_idx_reg] <= '0;
                    end
                    else if (pend_timer_reg[p_idx_reg] >= holdoff_reg)
                    begin
                        pend_timer_reg[p_idx_reg] <= '0;
                    end
                end
            end
            ST_LWRITE:
            begin
                cache_ip_reg[hit_reg ? hit_idx_reg : (cfree_reg ? cfree_idx_reg : old_idx_reg)]
                    <= ip_reg;
                cache_mac_reg[hit_reg ? hit_idx_reg : (cfree_reg ? cfree_idx_reg : old_idx_reg)]
                    <= mac_reg;
                cache_age_reg[hit_reg ? hit_idx_reg : (cfree_reg ? cfree_idx_reg : old_idx_reg)]
                    <= '0;
            end
            ST_TICK:
            begin
                if (idx_reg <= C_LAST && cache_valid_reg[ci])
                begin
                    cache_age_reg[ci] <= age_sat;
                end
                if (idx_reg <= P_LAST && pend_valid_reg[pi])
                begin
                    pend_timer_reg[pi] <= timer_sat;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cache_valid_reg <= '0;
            pend_valid_reg  <= '0;
            slot_valid_reg  <= '0;
            idx_reg         <= '0;
            hit_reg         <= 1'b0;
            hit_idx_reg     <= '0;
            cfree_reg       <= 1'b0;
            cfree_idx_reg   <= '0;
            old_idx_reg     <= '0;
            old_age_reg     <= '0;
            pfound_reg      <= 1'b0;
            p_idx_reg       <= '0;
            pfree_reg       <= 1'b0;
            pfree_idx_reg   <= '0;
            sfree_reg       <= 1'b0;
            s_idx_reg       <= '0;
            cnt_reg         <= '0;
            q_reg           <= '0;
            any_reg         <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    idx_reg    <= '0;
                    hit_reg    <= 1'b0;
                    cfree_reg  <= 1'b0;
                    pfound_reg <= 1'b0;
                    pfree_reg  <= 1'b0;
                    sfree_reg  <= 1'b0;
                    cnt_reg    <= '0;
                    q_reg      <= '0;
                    any_reg    <= 1'b0;
                    if (start)
                    begin
                        case (operation)
                            arpc_pkg::OP_SEND: state_reg <= ST_CSCAN;
                            arpc_pkg::OP_TICK: state_reg <= ST_TICK;
                            arpc_pkg::OP_RECV:
                            begin
                                if (addressed && payload_ok && frame_kind == arpc_pkg::FK_ARP)
                                begin
                                    state_reg <= ST_LSCAN;
                                end
                                else
                                begin
                                    state_reg <= ST_FINISH;
                                end
                            end
                            default: state_reg <= ST_FINISH;
                        endcase
                    end
                end
                ST_CSCAN:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (emit.valid)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else if (idx_reg == C_LAST)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_PSCAN;
                    end
                end
                ST_PSCAN, ST_RPSCAN:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (pend_valid_reg[pi] && pend_ip_reg[pi] == ip_reg && !pfound_reg)
                    begin
                        pfound_reg <= 1'b1;
                        p_idx_reg  <= pi;
                    end
                    if (!pend_valid_reg[pi] && !pfree_reg)
                    begin
                        pfree_reg     <= 1'b1;
                        pfree_idx_reg <= pi;
                    end
                    if (idx_reg == P_LAST)
                    begin
                        idx_reg <= '0;
                        if (state_reg == ST_PSCAN)
                        begin
                            state_reg <= ST_SSCAN;
                        end
                        else if (pfound_reg
                                 || (pend_valid_reg[pi] && pend_ip_reg[pi] == ip_reg))
                        begin
                            state_reg <= ST_RSLOT;
                        end
                        else
                        begin
                            state_reg <= ST_REPLY;
                        end
                    end
                end
                ST_SSCAN:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (!slot_valid_reg[si] && !sfree_reg)
                    begin
                        sfree_reg <= 1'b1;
                        s_idx_reg <= si;
                    end
                    if (slot_valid_reg[si] && slot_owner_reg[si] == p_sel)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (idx_reg == S_LAST)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_QUEUE;
                    end
                end
                ST_QUEUE:
                begin
                    if ((pfound_reg || pfree_reg) && sfree_reg)
                    begin
                        slot_valid_reg[s_idx_reg] <= 1'b1;
                        if (!pfound_reg)
                        begin
                            pend_valid_reg[pfree_idx_reg] <= 1'b1;
                        end
                    end
                    state_reg <= ST_FINISH;
                end
                ST_LSCAN:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (cache_valid_reg[ci] && cache_ip_reg[ci] == ip_reg && !hit_reg)
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= ci;
                    end
                    if (!cache_valid_reg[ci] && !cfree_reg)
                    begin
                        cfree_reg     <= 1'b1;
                        cfree_idx_reg <= ci;
                    end
                    // Oldest entry, lowest index among equal ages.
                    if (idx_reg == '0 || cache_age_reg[ci] > old_age_reg)
                    begin
                        old_idx_reg <= ci;
                        old_age_reg <= cache_age_reg[ci];
                    end
                    if (idx_reg == C_LAST)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_LWRITE;
                    end
                end
                ST_LWRITE:
                begin
                    cache_valid_reg[hit_reg ? hit_idx_reg
                                    : (cfree_reg ? cfree_idx_reg : old_idx_reg)] <= 1'b1;
                    state_reg <= ST_RPSCAN;
                end
                ST_RSLOT:
                begin
                    // One pass per queue position; a pass that finds nothing ends the release.
                    idx_reg <= idx_reg + 1'b1;
                    if (emit.valid)
                    begin
                        slot_valid_reg[si] <= 1'b0;
                        any_reg            <= 1'b1;
                    end
                    if (idx_reg == S_LAST)
                    begin
                        idx_reg <= '0;
                        if (any_reg || emit.valid)
                        begin
                            any_reg <= 1'b0;
                            q_reg   <= q_reg + 1'b1;
                        end
                        else
                        begin
                            pend_valid_reg[p_idx_reg] <= 1'b0;
                            state_reg                 <= ST_REPLY;
                        end
                    end
                end
                ST_REPLY:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_TICK:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg <= C_LAST && cache_valid_reg[ci] && age_sat >= lifetime_reg)
                    begin
                        cache_valid_reg[ci] <= 1'b0;
                    end
                    if (idx_reg == IW'(MAXN - 1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    arpc_out u_out
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .emit          (emit),
        .finish        (finish),
        .strobe        (strobe),
        .result_kind   (result_kind),
        .out_dst_mac   (out_dst_mac),
        .out_target_ip (out_target_ip),
        .out_handle    (out_handle),
        .last          (last)
    );

endmodule

/* sim/arp_resolution_cache_checker.sv */
// ----------------------------------------------------------------------------
// arp_resolution_cache_checker
// Watches the command, configuration and result channels of the ARP cache,
// predicts the results of every accepted transaction and compares them.
// ----------------------------------------------------------------------------
module arp_resolution_cache_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  operation,
    input  logic [31:0] peer_ip,
    input  logic [47:0] peer_mac,
    input  logic [31:0] arp_target_ip,
    input  logic [47:0] frame_dst_mac,
    input  logic [1:0]  frame_kind,
    input  logic        arp_is_request,
    input  logic        payload_ok,
    input  logic [15:0] datagram_handle,
    input  logic [15:0] elapsed_ms,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        strobe,
    input  logic [2:0]  result_kind,
    input  logic [47:0] out_dst_mac,
    input  logic [31:0] out_target_ip,
    input  logic [15:0] out_handle,
    input  logic        last,
    output int          fail_count,
    output int          pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NC = arpc_pkg::CACHE_ENTRIES_DEF;
    localparam int NP = arpc_pkg::PENDING_IPS_DEF;
    localparam int NS = arpc_pkg::PENDING_SLOTS_DEF;

    typedef struct {
        logic [2:0]  kind;
        logic [47:0] mac;
        logic [31:0] ip;
        logic [15:0] handle;
        logic        fin;
    } frame_rec_t;

    frame_rec_t expected_frames[$];

    logic [47:0] my_mac;
    logic [31:0] my_ip;
    logic [15:0] holdoff;
    logic [15:0] lifetime;

    logic        c_vld[NC];
    logic [31:0] c_ip[NC];
    logic [47:0] c_mac[NC];
    logic [16:0] c_age[NC];
    logic        p_vld[NP];
    logic [31:0] p_ip[NP];
    logic [16:0] p_tmr[NP];
    logic        s_vld[NS];
    int          s_own[NS];
    logic [15:0] s_hdl[NS];
    int          s_seq[NS];

    int added;

    assign pending_results = expected_frames.size();

    task automatic push_frame(input logic [2:0] k, input logic [47:0] m,
                              input logic [31:0] ip, input logic [15:0] h);
        frame_rec_t r;
        r.kind = k;
        r.mac = m;
        r.ip = ip;
        r.handle = h;
        r.fin = 1'b0;
        expected_frames.push_back(r);
        added++;
    endtask

    function automatic logic [16:0] sat16(input logic [16:0] a, input logic [15:0] b);
        logic [17:0] s;
        s = a + b;
        return (s > 18'hFFFF) ? 17'hFFFF : s[16:0];
    endfunction

    task automatic predict_send(input logic [31:0] ip, input logic [15:0] h);
        int c;
        int p;
        int s;
        int seq;
        bit fresh;
        c = -1;
        p = -1;
        s = -1;
        seq = 0;
        fresh = 1'b0;
        for (int i = 0; i < NC; i++)
            if (c < 0 && c_vld[i] && c_ip[i] == ip) c = i;
        if (c >= 0)
        begin
            push_frame(arpc_pkg::RK_FRAME, c_mac[c], '0, h);
            return;
        end
        for (int i = 0; i < NP; i++)
            if (p < 0 && p_vld[i] && p_ip[i] == ip) p = i;
        if (p < 0)
        begin
            fresh = 1'b1;
            for (int i = 0; i < NP; i++)
                if (p < 0 && !p_vld[i]) p = i;
        end
        for (int i = 0; i < NS; i++)
            if (s < 0 && !s_vld[i]) s = i;
        if (p < 0 || s < 0)
        begin
            push_frame(arpc_pkg::RK_DROP, '0, '0, h);
            return;
        end
        if (!fresh)
            for (int i = 0; i < NS; i++)
                if (s_vld[i] && s_own[i] == p) seq++;
        s_vld[s] = 1'b1;
        s_own[s] = p;
        s_hdl[s] = h;
        s_seq[s] = seq;
        if (fresh)
        begin
            p_vld[p] = 1'b1;
            p_ip[p] = ip;
            p_tmr[p] = '0;
        end
        else if (p_tmr[p] < holdoff)
            return;
        p_tmr[p] = '0;
        push_frame(arpc_pkg::RK_REQUEST, arpc_pkg::BCAST_MAC, ip, '0);
    endtask

    task automatic predict_learn(input logic [31:0] ip, input logic [47:0] mac);
        int c;
        int p;
        c = -1;
        p = -1;
        for (int i = 0; i < NC; i++)
            if (c < 0 && c_vld[i] && c_ip[i] == ip) c = i;
        if (c < 0)
            for (int i = 0; i < NC; i++)
                if (c < 0 && !c_vld[i]) c = i;
        if (c < 0)
        begin
            c = 0;
            for (int i = 1; i < NC; i++)
                if (c_age[i] > c_age[c]) c = i;
        end
        c_vld[c] = 1'b1;
        c_ip[c] = ip;
        c_mac[c] = mac;
        c_age[c] = '0;
        // Queued datagrams go out in the order they were queued.
        for (int i = 0; i < NP; i++)
            if (p < 0 && p_vld[i] && p_ip[i] == ip) p = i;
        if (p < 0) return;
        for (int q = 0; q < NS; q++)
            for (int i = 0; i < NS; i++)
                if (s_vld[i] && s_own[i] == p && s_seq[i] == q)
                begin
                    push_frame(arpc_pkg::RK_FRAME, mac, '0, s_hdl[i]);
                    s_vld[i] = 1'b0;
                end
        for (int i = 0; i < NS; i++)
            if (s_vld[i] && s_own[i] == p) s_vld[i] = 1'b0;
        p_vld[p] = 1'b0;
    endtask

    task automatic predict_transaction();
        added = 0;
        if (operation == arpc_pkg::OP_SEND)
            predict_send(peer_ip, datagram_handle);
        else if (operation == arpc_pkg::OP_RECV)
        begin
            if ((frame_dst_mac == my_mac || frame_dst_mac == arpc_pkg::BCAST_MAC) && payload_ok)
            begin
                if (frame_kind == arpc_pkg::FK_IPV4)
                    push_frame(arpc_pkg::RK_DELIVER, '0, '0, datagram_handle);
                else if (frame_kind == arpc_pkg::FK_ARP)
                begin
                    predict_learn(peer_ip, peer_mac);
                    if (arp_is_request && arp_target_ip == my_ip)
                        push_frame(arpc_pkg::RK_REPLY, peer_mac, peer_ip, '0);
                end
            end
        end
        else if (operation == arpc_pkg::OP_TICK)
        begin
            for (int i = 0; i < NC; i++)
                if (c_vld[i])
                begin
                    c_age[i] = sat16(c_age[i], elapsed_ms);
                    if (c_age[i] >= lifetime) c_vld[i] = 1'b0;
                end
            for (int i = 0; i < NP; i++)
                if (p_vld[i]) p_tmr[i] = sat16(p_tmr[i], elapsed_ms);
        end
        if (added > 0)
            expected_frames[expected_frames.size() - 1].fin = 1'b1;
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count = 0;
            my_mac = '0;
            my_ip = '0;
            holdoff = arpc_pkg::HOLDOFF_RESET;
            lifetime = arpc_pkg::LIFETIME_RESET;
            for (int i = 0; i < NC; i++) c_vld[i] = 1'b0;
            for (int i = 0; i < NP; i++) p_vld[i] = 1'b0;
            for (int i = 0; i < NS; i++) s_vld[i] = 1'b0;
            expected_frames.delete();
        end
        else
        begin
            if (strobe)
            begin
                if (expected_frames.size() == 0)
                    report_mismatch($sformatf("unexpected result kind %0d", result_kind));
                else
                begin
                    frame_rec_t e;
                    e = expected_frames.pop_front();
                    if (result_kind !== e.kind)
                        report_mismatch($sformatf("kind %0d, want %0d", result_kind, e.kind));
                    if (out_dst_mac !== e.mac)
                        report_mismatch($sformatf("mac %h, want %h", out_dst_mac, e.mac));
                    if (out_target_ip !== e.ip)
                        report_mismatch($sformatf("ip %h, want %h", out_target_ip, e.ip));
                    if (out_handle !== e.handle)
                        report_mismatch($sformatf("handle %h, want %h", out_handle, e.handle));
                    if (last !== e.fin)
                        report_mismatch($sformatf("last %b, want %b", last, e.fin));
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    arpc_pkg::CFG_OWN_MAC:  my_mac = cfg_data;
                    arpc_pkg::CFG_OWN_IP:   my_ip = cfg_data[31:0];
                    arpc_pkg::CFG_HOLDOFF:  holdoff = cfg_data[15:0];
                    arpc_pkg::CFG_LIFETIME: lifetime = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                predict_transaction();
        end
    end

endmodule

/* sim/tb_arp_resolution_cache_unit.sv */
// ----------------------------------------------------------------------------
// tb_arp_resolution_cache_unit
// Drives directed and random send, receive and tick transactions into the
// ARP cache under several configurations; the checker judges the results.
// ----------------------------------------------------------------------------
module tb_arp_resolution_cache_unit;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  operation;
    logic [31:0] peer_ip;
    logic [47:0] peer_mac;
    logic [31:0] arp_target_ip;
    logic [47:0] frame_dst_mac;
    logic [1:0]  frame_kind;
    logic        arp_is_request;
    logic        payload_ok;
    logic [15:0] datagram_handle;
    logic [15:0] elapsed_ms;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [47:0] cfg_data;
    logic        strobe;
    logic [2:0]  result_kind;
    logic [47:0] out_dst_mac;
    logic [31:0] out_target_ip;
    logic [15:0] out_handle;
    logic        last;
    int          fail_count;
    int          pending_results;

    logic [47:0] iface_mac;
    logic [31:0] iface_ip;
    logic [31:0] peer_pool[12];
    logic [47:0] peer_mac_pool[12];

    arp_resolution_cache_unit i_dut (.*);

    arp_resolution_cache_checker i_checker (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // A gap of zero keeps start high so the next transaction follows at once.
    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic issue(input logic [1:0] op, input logic [31:0] ip, input logic [47:0] mac,
                         input logic [31:0] tip, input logic [47:0] dst, input logic [1:0] fk,
                         input logic req, input logic ok, input logic [15:0] h,
                         input logic [15:0] ms);
        operation <= op;
        peer_ip <= ip;
        peer_mac <= mac;
        arp_target_ip <= tip;
        frame_dst_mac <= dst;
        frame_kind <= fk;
        arp_is_request <= req;
        payload_ok <= ok;
        datagram_handle <= h;
        elapsed_ms <= ms;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        random_gap();
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    // The last transaction may still be walking the tables after its final result.
    task automatic drain();
        start <= 1'b0;
        while (pending_results != 0 || busy) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic send_to(input int k);
        issue(arpc_pkg::OP_SEND, peer_pool[k], '0, '0, '0, '0, 1'b0, 1'b0, 16'($urandom), '0);
    endtask

    task automatic arp_from(input int k, input logic req);
        issue(arpc_pkg::OP_RECV, peer_pool[k], peer_mac_pool[k],
              ($urandom_range(0, 1) != 0) ? iface_ip : $urandom,
              ($urandom_range(0, 1) != 0) ? iface_mac : arpc_pkg::BCAST_MAC,
              arpc_pkg::FK_ARP, req, 1'b1, 16'($urandom), '0);
    endtask

    task automatic random_item();
        int k;
        int sel;
        k = $urandom_range(0, 11);
        sel = $urandom_range(0, 99);
        if (sel < 40)
            send_to(k);
        else if (sel < 65)
            arp_from(k, 1'($urandom_range(0, 1)));
        else if (sel < 75)
            issue(arpc_pkg::OP_RECV, $urandom, 48'($urandom()), $urandom, iface_mac,
                  arpc_pkg::FK_IPV4, 1'($urandom), 1'b1, 16'($urandom), 16'($urandom));
        else if (sel < 88)
            issue(arpc_pkg::OP_TICK, $urandom, 48'({$urandom, $urandom}), $urandom,
                  48'({$urandom, $urandom}), 2'($urandom), 1'($urandom), 1'($urandom),
                  16'($urandom),
                  ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000)));
        else
            // Noise: stray destinations, bad payloads, other ethertypes, unused operation.
            issue(2'($urandom), $urandom, 48'({$urandom, $urandom}), $urandom,
                  ($urandom_range(0, 1) != 0) ? 48'({$urandom, $urandom}) : iface_mac,
                  2'($urandom), 1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        operation = '0;
        peer_ip = '0;
        peer_mac = '0;
        arp_target_ip = '0;
        frame_dst_mac = '0;
        frame_kind = '0;
        arp_is_request = 1'b0;
        payload_ok = 1'b0;
        datagram_handle = '0;
        elapsed_ms = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        iface_mac = '0;
        iface_ip = '0;
        peer_pool[0] = '0;
        peer_pool[1] = '1;
        peer_mac_pool[0] = '0;
        peer_mac_pool[1] = '1;
        for (int i = 2; i < 12; i++)
        begin
            peer_pool[i] = $urandom;
            peer_mac_pool[i] = 48'({$urandom, $urandom});
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under reset configuration: own addresses are zero.
        send_to(0);
        send_to(0);
        send_to(1);
        arp_from(0, 1'b1);
        send_to(0);
        issue(arpc_pkg::OP_RECV, '0, '0, '0, 48'h1234, arpc_pkg::FK_IPV4, 1'b0, 1'b1,
              16'hFFFF, '0);
        issue(arpc_pkg::OP_RECV, '0, '0, '0, arpc_pkg::BCAST_MAC, arpc_pkg::FK_IPV4, 1'b0, 1'b1,
              16'h0000, '0);
        issue(arpc_pkg::OP_RECV, '0, '0, '0, arpc_pkg::BCAST_MAC, arpc_pkg::FK_IPV4, 1'b0, 1'b0,
              16'h1111, '0);
        issue(arpc_pkg::OP_RECV, '0, '0, '0, arpc_pkg::BCAST_MAC, 2'd2, 1'b0, 1'b1,
              16'h2222, '0);
        issue(arpc_pkg::OP_RECV, '0, '0, '0, arpc_pkg::BCAST_MAC, 2'd3, 1'b1, 1'b1,
              16'h3333, '0);
        issue(2'd3, '1, '1, '1, '1, '1, 1'b1, 1'b1, '1, '1);
        issue(arpc_pkg::OP_TICK, '0, '0, '0, '0, '0, 1'b0, 1'b0, '0, 16'd4999);
        send_to(1);
        issue(arpc_pkg::OP_TICK, '0, '0, '0, '0, '0, 1'b0, 1'b0, '0, 16'd1);
        send_to(1);
        issue(arpc_pkg::OP_TICK, '0, '0, '0, '0, '0, 1'b0, 1'b0, '0, 16'hFFFF);
        issue(arpc_pkg::OP_TICK, '0, '0, '0, '0, '0, 1'b0, 1'b0, '0, 16'hFFFF);
        send_to(0);
        // Fill the pending store until drops appear.
        for (int i = 0; i < 18; i++)
            issue(arpc_pkg::OP_SEND, 32'h0A00_0000 + (i % 9), '0, '0, '0, '0, 1'b0, 1'b0,
                  16'(i), '0);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    iface_mac = '1 - 1;
                    iface_ip = '1;
                end
                1:
                begin
                    iface_mac = 48'({$urandom, $urandom});
                    iface_ip = peer_pool[3];
                end
                default:
                begin
                    iface_mac = 48'({$urandom, $urandom});
                    iface_ip = $urandom;
                end
            endcase
            write_reg(arpc_pkg::CFG_OWN_MAC, iface_mac);
            write_reg(arpc_pkg::CFG_OWN_IP, {16'h0, iface_ip});
            write_reg(arpc_pkg::CFG_HOLDOFF, (phase == 0) ? 48'd1 : (phase == 1) ? 48'hFFFF :
                      (phase == 2) ? 48'd0 : 48'($urandom_range(1, 3000)));
            write_reg(arpc_pkg::CFG_LIFETIME, (phase == 0) ? 48'hFFFF : (phase == 1) ? 48'd1 :
                      (phase == 2) ? 48'd0 : 48'($urandom_range(1000, 9000)));
            cfg_write <= 1'b0;
            for (int i = 0; i < 21; i++)
                random_item();
            drain();
        end

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
